// ===== sv/fcp_pkg.sv =====
package fcp_pkg;

  // Defaults for the top-level parameters
  localparam int PARTITIONS_DEF    = 8;
  localparam int MAX_WRITE_LEN_DEF = 4096;

  // Field widths
  localparam int ADDR_W = 32;
  localparam int LEN_W  = 13;

  // Input modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_ERASE    = 2'd0;
  localparam logic [1:0] KIND_PROGRAM  = 2'd1;
  localparam logic [1:0] KIND_INVALID  = 2'd2;
  localparam logic [1:0] KIND_ACCEPTED = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_PAGE_LOG2   = 2'd0;
  localparam logic [1:0] CFG_SECTOR_LOG2 = 2'd1;
  localparam logic [1:0] CFG_MAX_ADDR    = 2'd2;

  // Configuration reset values
  localparam logic [3:0]  PAGE_LOG2_RST   = 4'd8;
  localparam logic [4:0]  SECTOR_LOG2_RST = 5'd12;
  localparam logic [31:0] MAX_ADDR_RST    = 32'h00FF_FFFF;

  // Clamp limits
  localparam logic [3:0] PAGE_LOG2_MIN   = 4'd4;
  localparam logic [3:0] PAGE_LOG2_MAX   = 4'd12;
  localparam logic [4:0] SECTOR_LOG2_MIN = 5'd12;
  localparam logic [4:0] SECTOR_LOG2_MAX = 5'd18;

  // Results per request, final status included
  localparam int RESULT_CAP = 34;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_FIT,
    S_START,
    S_CNT,
    S_FWD,
    S_SOFF,
    S_SFIT,
    S_ERASE,
    S_PROG,
    S_ADV,
    S_FIN
  } state_t;

endpackage

// ===== sv/flash_write_chunk_planner.sv =====
// Flash write chunk planner.
// Input channel (in_valid/in_ready): one beat is a partition load, a write request or a
// clear of the last-written address. Result channel (out_valid/out_ready): every input
// beat gives one or more result beats, the final one flagged by out_last. A write request
// gives a page program per page-bounded chunk, each led by a sector erase unless it runs
// forward in the last written sector, then an accepted or invalid status.
// Configuration channel (cfg_valid/cfg_ready, always ready): page size log2, sector size
// log2 and highest device address: the user writes them only while the block is idle;
// the block itself does not enforce this.
// Sequencing: one item is handled at a time and in_ready is high only in the idle state.
// A load, clear or request rejected at decode goes straight to its status beat. A write
// request passes its checks (partition fit, start range, result count), then per chunk a
// forward check, for a chunk needing an erase the sector offset, sector fit and erase
// beat, then the program beat and the address advance, and ends with the status beat.
// A small sequencer steps one shared 32-bit adder through every address sum and compare.
// Reset (rst_n low, synchronous): all partition entries invalid, last-written address all
// ones, configuration back to page 2^8, sector 2^12, three-byte addressing.
// Stalls: results leave through a single output register; while out_ready is low the
// sequencer holds in its emitting state, so nothing is lost or repeated.
module flash_write_chunk_planner #(
  parameter int PARTITIONS    = fcp_pkg::PARTITIONS_DEF,
  parameter int MAX_WRITE_LEN = fcp_pkg::MAX_WRITE_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  // input beats
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_mode,
  input  logic [7:0]                in_partition_index,
  input  logic [fcp_pkg::ADDR_W-1:0] in_entry_base,
  input  logic [fcp_pkg::ADDR_W-1:0] in_entry_size,
  input  logic [fcp_pkg::ADDR_W-1:0] in_write_offset,
  input  logic [fcp_pkg::LEN_W-1:0]  in_write_length,
  // result beats
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_kind,
  output logic [fcp_pkg::ADDR_W-1:0] out_flash_address,
  output logic [fcp_pkg::LEN_W-1:0]  out_chunk_length,
  output logic                      out_wide_address,
  output logic                      out_last
);
  import fcp_pkg::*;

  localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t              state_r, state_nxt;

  logic [3:0]          page_log2_r;
  logic [4:0]          sector_log2_r;
  logic [31:0]         max_addr_r;

  // partition table: base/size only read behind a set valid bit, so no reset
  logic [ADDR_W-1:0]   part_base_r [PARTITIONS];
  logic [ADDR_W-1:0]   part_size_r [PARTITIONS];
  logic [PARTITIONS-1:0] part_valid_r, part_valid_nxt;
  logic                tbl_we;

  logic [ADDR_W-1:0]   lw_r, lw_nxt;          // last written byte

  // captured input beat
  logic [1:0]          mode_r;
  logic [7:0]          idx_r;
  logic [ADDR_W-1:0]   ebase_r, esize_r, off_r;
  logic [LEN_W-1:0]    len_r;

  // working registers
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [ADDR_W-1:0]   psize_r, psize_nxt;
  logic [ADDR_W-1:0]   rem_r, rem_nxt;        // psize minus an offset
  logic                nb_r, nb_nxt;          // that subtraction did not borrow
  logic [ADDR_W-1:0]   a_r, a_nxt;            // current chunk address
  logic [ADDR_W-1:0]   soff_r, soff_nxt;      // sector offset inside partition
  logic [LEN_W-1:0]    rest_r, rest_nxt;
  logic [LEN_W-1:0]    chunk_r, chunk_nxt;
  logic [1:0]          kind_r, kind_nxt;      // status for the final beat

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_kind_r, out_kind_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;
  logic                out_wide_r, out_wide_nxt;
  logic                out_last_r, out_last_nxt;

  // ---------------------------------------------------------------------------
  // Derived configuration
  // ---------------------------------------------------------------------------
  logic [3:0]          pl;
  logic [4:0]          sl;
  logic [LEN_W-1:0]    page_len;
  logic [11:0]         pmask;
  logic [17:0]         smask;
  logic [ADDR_W-1:0]   sect_hi_mask;         // bits above the sector offset
  logic                wide;

  assign pl = (page_log2_r < PAGE_LOG2_MIN) ? PAGE_LOG2_MIN :
              (page_log2_r > PAGE_LOG2_MAX) ? PAGE_LOG2_MAX : page_log2_r;
  assign sl = (sector_log2_r < SECTOR_LOG2_MIN) ? SECTOR_LOG2_MIN :
              (sector_log2_r > SECTOR_LOG2_MAX) ? SECTOR_LOG2_MAX : sector_log2_r;
  assign page_len     = LEN_W'(1) << pl;
  assign pmask        = 12'(page_len - LEN_W'(1));
  assign smask        = 18'((19'd1 << sl) - 19'd1);
  assign sect_hi_mask = ~{14'd0, smask};
  assign wide         = |max_addr_r[31:24];

  // ---------------------------------------------------------------------------
  // Shared adder: every 32-bit add, subtract and magnitude compare goes here
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]   alu_a, alu_b;
  logic                alu_ci;
  logic [ADDR_W:0]     alu_sum;

  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_ci = 1'b0;
    case (state_r)
      S_FIT: begin                       // psize - offset
        alu_a = psize_r; alu_b = ~off_r; alu_ci = 1'b1;
      end
      S_START: begin                     // start address
        alu_a = base_r; alu_b = off_r;
      end
      S_FWD: begin                       // last written - address, carry means lw >= a
        alu_a = lw_r; alu_b = ~a_r; alu_ci = 1'b1;
      end
      S_SOFF: begin                      // address relative to partition
        alu_a = a_r; alu_b = ~base_r; alu_ci = 1'b1;
      end
      S_SFIT: begin                      // room left after sector offset
        alu_a = psize_r; alu_b = ~soff_r; alu_ci = 1'b1;
      end
      S_ERASE: begin                     // erase address
        alu_a = base_r; alu_b = soff_r;
      end
      S_PROG: begin                      // last byte of the chunk
        alu_a = a_r; alu_b = ADDR_W'(chunk_r - LEN_W'(1));
      end
      S_ADV: begin                       // next chunk address
        alu_a = a_r; alu_b = ADDR_W'(chunk_r);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + (ADDR_W + 1)'(alu_ci);

  // ---------------------------------------------------------------------------
  // Narrow helpers
  // ---------------------------------------------------------------------------
  logic                idx_ok, req_ok;
  logic [LEN_W-1:0]    pg_span;     // (start mod page) + len - 1
  logic [18:0]         sc_span;     // (start mod sector) + len - 1
  logic [10:0]         span_sum;    // extra pages + extra sectors
  logic [LEN_W-1:0]    room, chunk_w;
  logic                same_sector, forward, erase_bad, out_free;
  logic [LEN_W-1:0]    rest_left;

  assign idx_ok  = idx_r < 8'(PARTITIONS);
  assign req_ok  = (len_r != '0) && (len_r <= LEN_W'(MAX_WRITE_LEN)) && idx_ok &&
                   part_valid_r[idx_r[IDX_W-1:0]];

  assign pg_span  = LEN_W'(a_r[11:0] & pmask) + len_r - LEN_W'(1);
  assign sc_span  = 19'(a_r[17:0] & smask) + 19'(len_r) - 19'd1;
  assign span_sum = 11'(pg_span >> pl) + 11'(sc_span >> sl);

  assign room        = page_len - LEN_W'(a_r[11:0] & pmask);
  assign chunk_w     = (rest_r < room) ? rest_r : room;
  assign same_sector = ((a_r ^ lw_r) & sect_hi_mask) == '0;
  assign forward     = !alu_sum[ADDR_W] && same_sector;
  assign erase_bad   = !nb_r || ((rem_r & sect_hi_mask) == '0);
  assign rest_left   = rest_r - chunk_r;

  assign out_free = !out_valid_r || out_ready;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_DEC;
      S_DEC: begin
        if (mode_r == MODE_WRITE && req_ok) state_nxt = S_FIT;
        else                                state_nxt = S_FIN;
      end
      S_FIT:   state_nxt = S_START;
      S_START: state_nxt = (!nb_r || len_r > rem_r[LEN_W-1:0] && rem_r[31:LEN_W] == '0)
                           ? S_FIN : S_CNT;
      S_CNT:   state_nxt = (span_sum > 11'(RESULT_CAP - 3)) ? S_FIN : S_FWD;
      S_FWD:   state_nxt = forward ? S_PROG : S_SOFF;
      S_SOFF:  state_nxt = S_SFIT;
      S_SFIT:  state_nxt = S_ERASE;
      S_ERASE: begin
        if (erase_bad)     state_nxt = S_FIN;
        else if (out_free) state_nxt = S_PROG;
      end
      S_PROG:  if (out_free) state_nxt = S_ADV;
      S_ADV:   state_nxt = (rest_left == '0) ? S_FIN : S_FWD;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    part_valid_nxt = part_valid_r;
    tbl_we         = 1'b0;
    lw_nxt         = lw_r;
    base_nxt       = base_r;
    psize_nxt      = psize_r;
    rem_nxt        = rem_r;
    nb_nxt         = nb_r;
    a_nxt          = a_r;
    soff_nxt       = soff_r;
    rest_nxt       = rest_r;
    chunk_nxt      = chunk_r;
    kind_nxt       = kind_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_addr_nxt   = out_addr_r;
    out_len_nxt    = out_len_r;
    out_wide_nxt   = out_wide_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_DEC: begin
        kind_nxt = KIND_INVALID;
        case (mode_r)
          MODE_LOAD: begin
            if (idx_ok) begin
              tbl_we = 1'b1;
              part_valid_nxt[idx_r[IDX_W-1:0]] = 1'b1;
              kind_nxt = KIND_ACCEPTED;
            end
          end
          MODE_CLEAR: begin
            lw_nxt   = '1;
            kind_nxt = KIND_ACCEPTED;
          end
          MODE_WRITE: begin
            if (req_ok) begin
              base_nxt  = part_base_r[idx_r[IDX_W-1:0]];
              psize_nxt = part_size_r[idx_r[IDX_W-1:0]];
            end
          end
          default: kind_nxt = KIND_INVALID;
        endcase
      end
      S_FIT: begin
        rem_nxt = alu_sum[ADDR_W-1:0];
        nb_nxt  = alu_sum[ADDR_W];
      end
      S_START: a_nxt = alu_sum[ADDR_W-1:0];
      S_CNT: begin
        rest_nxt = len_r;
        kind_nxt = KIND_ACCEPTED;
        if (span_sum > 11'(RESULT_CAP - 3)) kind_nxt = KIND_INVALID;
      end
      S_FWD:  chunk_nxt = chunk_w;
      S_SOFF: soff_nxt  = alu_sum[ADDR_W-1:0] & sect_hi_mask;
      S_SFIT: begin
        rem_nxt = alu_sum[ADDR_W-1:0];
        nb_nxt  = alu_sum[ADDR_W];
      end
      S_ERASE: begin
        if (erase_bad) begin
          kind_nxt = KIND_INVALID;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ERASE;
          out_addr_nxt  = alu_sum[ADDR_W-1:0];
          out_len_nxt   = '0;
          out_wide_nxt  = wide;
          out_last_nxt  = 1'b0;
        end
      end
      S_PROG: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_PROGRAM;
          out_addr_nxt  = a_r;
          out_len_nxt   = chunk_r;
          out_wide_nxt  = wide;
          out_last_nxt  = 1'b0;
          lw_nxt        = alu_sum[ADDR_W-1:0];
        end
      end
      S_ADV: begin
        a_nxt    = alu_sum[ADDR_W-1:0];
        rest_nxt = rest_left;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_addr_nxt  = '0;
          out_len_nxt   = '0;
          out_wide_nxt  = 1'b0;
          out_last_nxt  = 1'b1;
        end
      end
      default: kind_nxt = kind_r;
    endcase
  end

  // a rejected length check in S_START still needs an invalid status
  logic start_bad;
  assign start_bad = (state_r == S_START) &&
                     (!nb_r || (len_r > rem_r[LEN_W-1:0] && rem_r[31:LEN_W] == '0));

  // ---------------------------------------------------------------------------
  // Clocked
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      page_log2_r   <= PAGE_LOG2_RST;
      sector_log2_r <= SECTOR_LOG2_RST;
      max_addr_r    <= MAX_ADDR_RST;
      part_valid_r  <= '0;
      lw_r          <= '1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      part_valid_r <= part_valid_nxt;
      lw_r         <= lw_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PAGE_LOG2:   page_log2_r   <= cfg_data[3:0];
          CFG_SECTOR_LOG2: sector_log2_r <= cfg_data[4:0];
          CFG_MAX_ADDR:    max_addr_r    <= cfg_data;
          default:         max_addr_r    <= max_addr_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r  <= in_mode;
      idx_r   <= in_partition_index;
      ebase_r <= in_entry_base;
      esize_r <= in_entry_size;
      off_r   <= in_write_offset;
      len_r   <= in_write_length;
    end
    if (tbl_we) begin
      part_base_r[idx_r[IDX_W-1:0]] <= ebase_r;
      part_size_r[idx_r[IDX_W-1:0]] <= esize_r;
    end
    base_r     <= base_nxt;
    psize_r    <= psize_nxt;
    rem_r      <= rem_nxt;
    nb_r       <= nb_nxt;
    a_r        <= a_nxt;
    soff_r     <= soff_nxt;
    rest_r     <= rest_nxt;
    chunk_r    <= chunk_nxt;
    kind_r     <= start_bad ? KIND_INVALID : kind_nxt;
    out_kind_r <= out_kind_nxt;
    out_addr_r <= out_addr_nxt;
    out_len_r  <= out_len_nxt;
    out_wide_r <= out_wide_nxt;
    out_last_r <= out_last_nxt;
  end

  assign cfg_ready         = 1'b1;
  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_flash_address = out_addr_r;
  assign out_chunk_length  = out_len_r;
  assign out_wide_address  = out_wide_r;
  assign out_last          = out_last_r;

endmodule
